FILE: rtl/core/lst_pkg.sv
// lap and sector timer package: item types, operation and result codes,
// command characters and default settings. no dependencies.
package lst_pkg;

  localparam int DEF_COUNT_WIDTH = 24;
  localparam int TIME_W          = 24;
  localparam int LOCK_W          = 16;
  localparam int KIND_W          = 3;
  localparam logic [LOCK_W-1:0] LOCKOUT_RESET = 16'd200;

  // input operations
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_CMD   = 2'd1;
  localparam logic [1:0] OP_GATE1 = 2'd2;
  localparam logic [1:0] OP_GATE2 = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACK     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LAP     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SECTOR1 = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SECTOR2 = 3'd4;

  // command characters
  localparam logic [7:0] CMD_PING  = 8'h72;  // r
  localparam logic [7:0] CMD_START = 8'h73;  // s
  localparam logic [7:0] CMD_STOP  = 8'h70;  // p
  localparam logic [7:0] CMD_ONE   = 8'h31;  // 1
  localparam logic [7:0] CMD_TWO   = 8'h32;  // 2
  localparam logic [7:0] CMD_BEST  = 8'h62;  // b

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] cmd_byte;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] time_ticks;
    logic              is_best;
    logic              laser_one;
    logic              laser_two;
    logic              last;
  } out_item_t;

  // results produced by one accepted item
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } lst_push_t;

endpackage

FILE: rtl/core/lst_core.sv
// lap and sector timer core: flags, tick counters and bests, updated once
// per accepted item, with the results of that item. depends on lst_pkg.
module lst_core
  import lst_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  in_item_t          item,
  input  logic [LOCK_W-1:0] lockout,
  output lst_push_t         push
);

  localparam int WIDE_W = (COUNT_WIDTH > TIME_W) ? COUNT_WIDTH : TIME_W;
  localparam int CMP_W  = (COUNT_WIDTH > LOCK_W) ? COUNT_WIDTH : LOCK_W;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  logic enabled, started, sector_mode;
  logic gate_one_enabled, gate_two_enabled, gate_one_armed, gate_two_armed;
  cnt_t lap_count, sector_one_count, sector_two_count;
  cnt_t best_lap, best_sector_one, best_sector_two;

  logic enabled_next, started_next, sector_mode_next;
  logic gate_one_enabled_next, gate_two_enabled_next;
  logic gate_one_armed_next, gate_two_armed_next;
  cnt_t lap_count_next, sector_one_count_next, sector_two_count_next;
  cnt_t best_lap_next, best_sector_one_next, best_sector_two_next;
  lst_push_t res;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  function automatic logic [TIME_W-1:0] clamp(input cnt_t v);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(v);
    return (w > WIDE_W'({TIME_W{1'b1}})) ? {TIME_W{1'b1}} : w[TIME_W-1:0];
  endfunction

  function automatic logic new_best(input cnt_t t, input cnt_t best);
    return (best == '0) || (t < best);
  endfunction

  always_comb begin
    out_item_t r;
    logic      nb;
    cnt_t      lap_inc;

    enabled_next          = enabled;
    started_next          = started;
    sector_mode_next      = sector_mode;
    gate_one_enabled_next = gate_one_enabled;
    gate_two_enabled_next = gate_two_enabled;
    gate_one_armed_next   = gate_one_armed;
    gate_two_armed_next   = gate_two_armed;
    lap_count_next        = lap_count;
    sector_one_count_next = sector_one_count;
    sector_two_count_next = sector_two_count;
    best_lap_next         = best_lap;
    best_sector_one_next  = best_sector_one;
    best_sector_two_next  = best_sector_two;
    lap_inc               = sat_inc(lap_count);
    nb                    = 1'b0;

    r = '0;
    r.laser_one = gate_one_enabled;
    r.laser_two = gate_two_enabled;
    r.last      = 1'b1;
    res        = '0;
    res.first  = r;
    res.second = r;

    case (item.op)
      OP_TICK: begin
        if (started) begin
          lap_count_next = lap_inc;
          if (gate_one_armed) sector_two_count_next = sat_inc(sector_two_count);
          if (gate_two_armed) sector_one_count_next = sat_inc(sector_one_count);
          if (!gate_one_armed && !sector_mode &&
              (CMP_W'(lap_inc) > CMP_W'(lockout))) begin
            gate_one_armed_next = 1'b1;
          end
        end
      end
      OP_CMD: begin
        if (item.cmd_byte == CMD_PING) begin
          res.first.kind = KIND_ACK;
        end else begin
          if (item.cmd_byte == CMD_START && !enabled) begin
            enabled_next          = 1'b1;
            gate_one_enabled_next = 1'b1;
            gate_one_armed_next   = 1'b1;
            gate_two_enabled_next = sector_mode;
            gate_two_armed_next   = 1'b0;
          end else if (item.cmd_byte == CMD_STOP && enabled) begin
            enabled_next          = 1'b0;
            started_next          = 1'b0;
            gate_one_enabled_next = 1'b0;
            gate_one_armed_next   = 1'b0;
            gate_two_enabled_next = 1'b0;
            gate_two_armed_next   = 1'b0;
          end else if (item.cmd_byte == CMD_ONE && !enabled) begin
            sector_mode_next = 1'b0;
          end else if (item.cmd_byte == CMD_TWO && !enabled) begin
            sector_mode_next = 1'b1;
          end else if (item.cmd_byte == CMD_BEST && !enabled) begin
            best_lap_next        = '0;
            best_sector_one_next = '0;
            best_sector_two_next = '0;
          end
          // status carries the laser levels after the command
          res.first.kind      = KIND_STATUS;
          res.first.laser_one = gate_one_enabled_next;
          res.first.laser_two = gate_two_enabled_next;
        end
        res.count = 2'd1;
      end
      OP_GATE1: begin
        if (gate_one_enabled && gate_one_armed) begin
          if (started) begin
            if (gate_two_enabled) begin
              nb = new_best(sector_two_count, best_sector_two);
              if (nb) best_sector_two_next = sector_two_count;
              res.first.kind       = KIND_SECTOR2;
              res.first.time_ticks = clamp(sector_two_count);
              res.first.is_best    = nb;
              res.first.last       = 1'b0;
              sector_one_count_next = '0;
              gate_two_armed_next   = 1'b1;
              nb = new_best(lap_count, best_lap);
              if (nb) best_lap_next = lap_count;
              res.second.kind       = KIND_LAP;
              res.second.time_ticks = clamp(lap_count);
              res.second.is_best    = nb;
              res.count = 2'd2;
            end else begin
              nb = new_best(lap_count, best_lap);
              if (nb) best_lap_next = lap_count;
              res.first.kind       = KIND_LAP;
              res.first.time_ticks = clamp(lap_count);
              res.first.is_best    = nb;
              res.count = 2'd1;
            end
            lap_count_next = '0;
          end else begin
            // first crossing only starts timing
            lap_count_next        = '0;
            sector_one_count_next = '0;
            started_next          = 1'b1;
            if (gate_two_enabled) gate_two_armed_next = 1'b1;
          end
          gate_one_armed_next = 1'b0;
        end
      end
      default: begin
        if (started && gate_two_enabled && gate_two_armed) begin
          nb = new_best(sector_one_count, best_sector_one);
          if (nb) best_sector_one_next = sector_one_count;
          res.first.kind       = KIND_SECTOR1;
          res.first.time_ticks = clamp(sector_one_count);
          res.first.is_best    = nb;
          res.count = 2'd1;
          sector_two_count_next = '0;
          gate_one_armed_next   = 1'b1;
          gate_two_armed_next   = 1'b0;
        end
      end
    endcase
  end

  assign push = fire ? res : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled          <= 1'b0;
      started          <= 1'b0;
      sector_mode      <= 1'b0;
      gate_one_enabled <= 1'b0;
      gate_two_enabled <= 1'b0;
      gate_one_armed   <= 1'b0;
      gate_two_armed   <= 1'b0;
      lap_count        <= '0;
      sector_one_count <= '0;
      sector_two_count <= '0;
      best_lap         <= '0;
      best_sector_one  <= '0;
      best_sector_two  <= '0;
    end else if (fire) begin
      enabled          <= enabled_next;
      started          <= started_next;
      sector_mode      <= sector_mode_next;
      gate_one_enabled <= gate_one_enabled_next;
      gate_two_enabled <= gate_two_enabled_next;
      gate_one_armed   <= gate_one_armed_next;
      gate_two_armed   <= gate_two_armed_next;
      lap_count        <= lap_count_next;
      sector_one_count <= sector_one_count_next;
      sector_two_count <= sector_two_count_next;
      best_lap         <= best_lap_next;
      best_sector_one  <= best_sector_one_next;
      best_sector_two  <= best_sector_two_next;
    end
  end

endmodule

FILE: rtl/core/lst_outq.sv
// lap and sector timer result queue: four registered entries, takes up to
// two results per cycle, hands out one per ready cycle. depends on lst_pkg.
module lst_outq
  import lst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  lst_push_t push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  out_item_t  entries [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign out_item  = entries[rd_ptr];
  // space for the worst case of two results
  assign room      = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.first;
    if (push.count == 2'd2) entries[wr_ptr + 2'd1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push.count) - 3'(pop);
    end
  end

endmodule

FILE: rtl/core/lap_and_sector_timer.sv
// lap and sector timer top level: apb register for the lockout, core state
// and result queue. depends on lst_pkg, lst_core, lst_outq.
// results of an item are registered in the queue when it is accepted.
// throughput: one item per cycle while in_ready; a two-gate lap gives two
// results, sector two then lap. the four-entry queue sets input ready:
// ready while it holds two results or fewer, independent of out_ready.
// reset (synchronous): clears flags, counters, bests and queue; lockout 200.
module lap_and_sector_timer
  import lst_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item
);

  logic [LOCK_W-1:0] lockout;
  logic              sel_lockout;
  lst_push_t         push;
  logic              fire;

  assign pready      = 1'b1;
  assign sel_lockout = (paddr[2] == 1'b0);
  assign prdata      = sel_lockout ? 32'(lockout) : '0;
  assign fire        = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout <= LOCKOUT_RESET;
    end else if (psel && penable && pwrite && pready && sel_lockout) begin
      lockout <= pwdata[LOCK_W-1:0];
    end
  end

  lst_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .lockout(lockout),
    .push   (push)
  );

  lst_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

FILE: rtl/core/lst_checker.sv
// lap and sector timer port checker and its bind to the top level.
// depends on lst_pkg and lap_and_sector_timer.
module lst_checker
  import lst_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.kind == KIND_STATUS || out_item.kind == KIND_ACK)
      |-> out_item.time_ticks == '0 && !out_item.is_best && out_item.last)
    else $error("status or ack result carries time, best or no last mark");

  a_sector2_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_SECTOR2 |-> !out_item.last)
    else $error("sector two result marked last");

  a_sector2_then_lap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_item.kind == KIND_SECTOR2
      |=> out_valid && out_item.kind == KIND_LAP && out_item.last)
    else $error("sector two result not followed by lap result");

endmodule

bind lap_and_sector_timer lst_checker u_lst_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);
